### rtl/core/sdb_pkg.sv
package sdb_pkg;

  localparam int NUM_PIXELS_DEF = 65536;

  localparam int IDX_W  = 16;
  localparam int PIX_W  = 8;
  localparam int GAIN_W = 4;
  localparam int VAR_W  = 8;
  localparam int CFG_W  = 8;
  localparam int PROD_W = PIX_W + GAIN_W;

  localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(2);
  localparam logic [VAR_W-1:0]  VAR_MIN_RST = VAR_W'(2);
  localparam logic [VAR_W-1:0]  VAR_MAX_RST = VAR_W'(255);

  typedef enum logic [1:0] {
    CFG_GAIN    = 2'd0,
    CFG_VAR_MIN = 2'd1,
    CFG_VAR_MAX = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    OP_INIT   = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

endpackage

### rtl/core/sdb_slot.sv
module sdb_slot
  import sdb_pkg::*;
#(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF,
  parameter int AW         = $clog2(NUM_PIXELS)
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [IDX_W-1:0] idx,
  output logic [AW-1:0]    slot
);

  // Two-stage map of a pixel index onto a store slot (index modulo depth).
  generate
    if (NUM_PIXELS >= (1 << IDX_W)) begin : g_direct
      logic [IDX_W-1:0] idx_d;

      always_ff @(posedge clk) begin
        if (adv) begin
          idx_d <= idx;
          slot  <= AW'(idx_d);
        end
      end
    end else begin : g_recip
      localparam int          REC_SH = 32;
      localparam logic [31:0] RECIP  = 32'((64'd1 << REC_SH) / 64'(NUM_PIXELS));
      localparam logic [IDX_W:0] DEPTH = (IDX_W+1)'(NUM_PIXELS);

      logic [IDX_W+31:0] prod;
      logic [IDX_W-1:0]  quo;
      logic [IDX_W-1:0]  idx_d;
      logic [2*IDX_W:0]  back;
      logic [IDX_W:0]    rem;
      logic [IDX_W:0]    rem_fix;

      // Quotient estimate is low by at most one; one subtract corrects it.
      assign prod    = (IDX_W+32)'(idx) * (IDX_W+32)'(RECIP);
      assign back    = (2*IDX_W+1)'(quo) * (2*IDX_W+1)'(DEPTH);
      assign rem     = {1'b0, idx_d} - back[IDX_W:0];
      assign rem_fix = (rem >= DEPTH) ? (rem - DEPTH) : rem;

      always_ff @(posedge clk) begin
        if (adv) begin
          quo   <= prod[REC_SH +: IDX_W];
          idx_d <= idx;
          slot  <= rem_fix[AW-1:0];
        end
      end
    end
  endgenerate

endmodule

### rtl/core/sigma_delta_background.sv
// Channel   Handshake              Payload
// in        in_valid / in_ready    opcode, pixel_index, pixel_value
// out       out_valid / out_ready  out_index, abs_diff, foreground
// cfg       cfg_we                 cfg_index, cfg_data
//
// One item per cycle unless the output stalls; each item passes through the
// slot map (two stages), mean update, gain multiply, variance update, output register.
// Mean and variance live in single-port-write RAMs; back-to-back hits on one
// pixel are bypassed from the stage that writes. The stores are not cleared.
// Synchronous reset clears valid bits and loads config defaults; a stalled output holds
// the whole pipe, so nothing is lost or repeated.
module sigma_delta_background
  import sdb_pkg::*;
#(
  parameter int NUM_PIXELS = NUM_PIXELS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             opcode,
  input  logic [IDX_W-1:0] pixel_index,
  input  logic [PIX_W-1:0] pixel_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_index,
  output logic [PIX_W-1:0] abs_diff,
  output logic             foreground,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int AW = $clog2(NUM_PIXELS);

  logic              adv;
  logic [GAIN_W-1:0] gain;
  logic [VAR_W-1:0]  var_min;
  logic [VAR_W-1:0]  var_max;

  // Stage P1 / P2: slot mapping
  logic              p1_v, p2_v;
  logic              p1_op, p2_op;
  logic [IDX_W-1:0]  p1_idx, p2_idx;
  logic [PIX_W-1:0]  p1_x, p2_x;
  logic [AW-1:0]     p2_slot;

  // Stage A: mean update
  logic              a_v, a_op;
  logic [IDX_W-1:0]  a_idx;
  logic [PIX_W-1:0]  a_x;
  logic [AW-1:0]     a_slot;
  logic [PIX_W-1:0]  mean_rd;
  logic              a_fwd;
  logic [PIX_W-1:0]  a_fwd_m;
  logic [PIX_W-1:0]  m_old, m_new, m_wr, a_d;

  // Stage B: gain multiply
  logic              b_v, b_op;
  logic [IDX_W-1:0]  b_idx;
  logic [AW-1:0]     b_slot;
  logic [PIX_W-1:0]  b_d;
  logic [PROD_W-1:0] b_prod;

  // Stage C: variance update
  logic              c_v, c_op;
  logic [IDX_W-1:0]  c_idx;
  logic [AW-1:0]     c_slot;
  logic [PIX_W-1:0]  c_d;
  logic [PROD_W-1:0] c_target;
  logic [VAR_W-1:0]  var_rd;
  logic              c_fwd;
  logic [VAR_W-1:0]  c_fwd_v;
  logic [VAR_W-1:0]  v_old, v_clamp, v_wr;
  logic [VAR_W:0]    v_step, v_hi;
  logic              c_fg;

  logic [PIX_W-1:0]  mean_mem [NUM_PIXELS];
  logic [VAR_W-1:0]  var_mem  [NUM_PIXELS];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= GAIN_RST;
      var_min <= VAR_MIN_RST;
      var_max <= VAR_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GAIN:    gain    <= cfg_data[GAIN_W-1:0];
        CFG_VAR_MIN: var_min <= cfg_data[VAR_W-1:0];
        CFG_VAR_MAX: var_max <= cfg_data[VAR_W-1:0];
        default:     ;
      endcase
    end
  end

  sdb_slot #(
    .NUM_PIXELS (NUM_PIXELS),
    .AW         (AW)
  ) u_slot (
    .clk  (clk),
    .adv  (adv),
    .idx  (pixel_index),
    .slot (p2_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v      <= 1'b0;
      p2_v      <= 1'b0;
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      p1_v      <= in_valid;
      p2_v      <= p1_v;
      a_v       <= p2_v;
      b_v       <= a_v;
      c_v       <= b_v;
      out_valid <= c_v;
    end
  end

  // Mean update
  assign m_old = a_fwd ? a_fwd_m : mean_rd;

  always_comb begin
    if (m_old < a_x) begin
      m_new = m_old + PIX_W'(1);
    end else if (m_old > a_x) begin
      m_new = m_old - PIX_W'(1);
    end else begin
      m_new = m_old;
    end
    a_d  = (m_new > a_x) ? (m_new - a_x) : (a_x - m_new);
    m_wr = (a_op == OP_UPDATE) ? m_new : a_x;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_op   <= opcode;
      p1_idx  <= pixel_index;
      p1_x    <= pixel_value;
      p2_op   <= p1_op;
      p2_idx  <= p1_idx;
      p2_x    <= p1_x;

      a_op    <= p2_op;
      a_idx   <= p2_idx;
      a_x     <= p2_x;
      a_slot  <= p2_slot;
      mean_rd <= mean_mem[p2_slot];
      // bypass the write leaving stage A at this same edge
      a_fwd   <= a_v && (a_slot == p2_slot);
      a_fwd_m <= m_wr;
      if (a_v) begin
        mean_mem[a_slot] <= m_wr;
      end

      b_op    <= a_op;
      b_idx   <= a_idx;
      b_slot  <= a_slot;
      b_d     <= a_d;
    end
  end

  assign b_prod = PROD_W'(gain) * PROD_W'(b_d);

  // Variance update and clamp
  assign v_old = c_fwd ? c_fwd_v : var_rd;

  always_comb begin
    if (PROD_W'(v_old) < c_target) begin
      v_step = {1'b0, v_old} + (VAR_W+1)'(1);
    end else if (PROD_W'(v_old) > c_target) begin
      v_step = {1'b0, v_old} - (VAR_W+1)'(1);
    end else begin
      v_step = {1'b0, v_old};
    end
    v_hi    = (v_step > {1'b0, var_max}) ? {1'b0, var_max} : v_step;
    v_clamp = (v_hi[VAR_W-1:0] < var_min) ? var_min : v_hi[VAR_W-1:0];
    v_wr    = (c_op == OP_UPDATE) ? v_clamp : var_min;
    c_fg    = (c_op == OP_UPDATE) && (c_d >= v_clamp);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_op     <= b_op;
      c_idx    <= b_idx;
      c_slot   <= b_slot;
      c_d      <= b_d;
      c_target <= b_prod;
      var_rd   <= var_mem[b_slot];
      // bypass the write leaving stage C at this same edge
      c_fwd    <= c_v && (c_slot == b_slot);
      c_fwd_v  <= v_wr;
      if (c_v) begin
        var_mem[c_slot] <= v_wr;
      end

      out_index  <= c_idx;
      abs_diff   <= (c_op == OP_UPDATE) ? c_d : '0;
      foreground <= c_fg;
    end
  end

endmodule
